FILE: sv/lfu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU page replacement block.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int FRAME_COUNT = 4;
    localparam int FRAME_W     = $clog2(FRAME_COUNT);
    localparam int LEAF_COUNT  = 1 << FRAME_W;

    localparam int PAGE_W  = 16;
    localparam int COUNT_W = 16;
    localparam int STAMP_W = 32;
    localparam int FAULT_W = 16;
    localparam int INDEX_W = 4;
    localparam int KEY_W   = COUNT_W + STAMP_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    typedef logic [FRAME_W-1:0] t_frame_idx;

    typedef struct packed {
        logic               valid;
        logic [PAGE_W-1:0]  page;
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] stamp;
    } t_frame;

    typedef struct packed {
        t_frame_idx index;
    } t_victim;

endpackage
`default_nettype wire

FILE: sv/lfu_victim_sel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_victim_sel
// Picks the frame with the lowest use count, then oldest stamp, then lowest
// index, through a comparison tree over all frames.
// ----------------------------------------------------------------------------
module lfu_victim_sel (
    input  lfu_pkg::t_frame  i_frame [lfu_pkg::FRAME_COUNT],
    output lfu_pkg::t_victim o_victim
);
    import lfu_pkg::*;

    logic [KEY_W-1:0] node_key [2*LEAF_COUNT];
    t_frame_idx       node_idx [2*LEAF_COUNT];

    always_comb begin
        node_key[0] = '1;
        node_idx[0] = '0;
        // leaves; empty frames rank as count 0 and stamp 0
        for (int i = 0; i < LEAF_COUNT; i++) begin
            if (i < FRAME_COUNT) begin
                node_key[LEAF_COUNT+i] = i_frame[i].valid ?
                    {i_frame[i].count, i_frame[i].stamp} : '0;
            end else begin
                node_key[LEAF_COUNT+i] = '1;
            end
            node_idx[LEAF_COUNT+i] = t_frame_idx'(i);
        end
        // left child holds the lower indices, so it wins on a tie
        for (int n = LEAF_COUNT - 1; n >= 1; n--) begin
            if (node_key[2*n+1] < node_key[2*n]) begin
                node_key[n] = node_key[2*n+1];
                node_idx[n] = node_idx[2*n+1];
            end else begin
                node_key[n] = node_key[2*n];
                node_idx[n] = node_idx[2*n];
            end
        end
        o_victim.index = node_idx[1];
    end

endmodule
`default_nettype wire

FILE: sv/lfu_page_replacement_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_page_replacement_top
// LFU page replacement over a small fully associative frame set, ties broken
// by oldest load, then lowest frame index.
// ----------------------------------------------------------------------------
// a taken request passes the input register, then the result register, to o_strobe
// throughput: one request per cycle; busy stays low, lookup and update of all
//   frames happen combinationally between the input and result registers
// reset: synchronous, active low; empties all frames, clears stamp and fault
//   counters; results cannot be held off by the receiver
module lfu_page_replacement_top (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire  [lfu_pkg::PAGE_W-1:0]    i_page_number,
    input  wire                           i_last_reference,
    output logic                          o_strobe,
    output logic                          o_hit,
    output logic [lfu_pkg::INDEX_W-1:0]   o_frame_index,
    output logic [lfu_pkg::FAULT_W-1:0]   o_fault_count,
    output logic                          o_sequence_end
);
    import lfu_pkg::*;

    // input register
    logic              r_req_valid;
    logic [PAGE_W-1:0] r_page;
    logic              r_last;

    // frame state
    t_frame               r_frame [FRAME_COUNT];
    t_frame               n_frame [FRAME_COUNT];
    logic [STAMP_W-1:0]   r_stamp, n_stamp;
    logic [FAULT_W-1:0]   r_fault_total, n_fault_total;

    // result register
    logic               r_res_strobe;
    logic               r_res_hit;
    logic [INDEX_W-1:0] r_res_index;
    logic [FAULT_W-1:0] r_res_fault;
    logic               r_res_end;

    logic       hit;
    t_frame_idx hit_idx;
    t_frame_idx sel_idx;
    t_victim    victim;

    assign busy = 1'b0;

    lfu_victim_sel u_victim_sel (
        .i_frame  (r_frame),
        .o_victim (victim)
    );

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
            if (r_frame[i].valid && (r_frame[i].page == r_page)) begin
                hit     = 1'b1;
                hit_idx = t_frame_idx'(i);
            end
        end
        sel_idx = hit ? hit_idx : victim.index;
    end

    always_comb begin
        n_frame       = r_frame;
        n_stamp       = r_stamp;
        n_fault_total = r_fault_total;
        if (r_req_valid) begin
            if (hit) begin
                if (r_frame[sel_idx].count != COUNT_MAX) begin
                    n_frame[sel_idx].count = r_frame[sel_idx].count + 1'b1;
                end
            end else begin
                n_frame[sel_idx].valid = 1'b1;
                n_frame[sel_idx].page  = r_page;
                n_frame[sel_idx].count = COUNT_W'(1);
                n_frame[sel_idx].stamp = r_stamp;
                if (r_stamp != STAMP_MAX) begin
                    n_stamp = r_stamp + 1'b1;
                end
                if (r_fault_total != FAULT_MAX) begin
                    n_fault_total = r_fault_total + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid   <= 1'b0;
            r_res_strobe  <= 1'b0;
            r_stamp       <= '0;
            r_fault_total <= '0;
            for (int i = 0; i < FRAME_COUNT; i++) begin
                r_frame[i] <= '0;
            end
        end else begin
            r_req_valid   <= start && !busy;
            r_res_strobe  <= r_req_valid;
            r_stamp       <= n_stamp;
            r_fault_total <= n_fault_total;
            for (int i = 0; i < FRAME_COUNT; i++) begin
                r_frame[i] <= n_frame[i];
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_page <= i_page_number;
            r_last <= i_last_reference;
        end
        if (r_req_valid) begin
            r_res_hit   <= hit;
            r_res_index <= INDEX_W'(sel_idx);
            r_res_fault <= n_fault_total;
            r_res_end   <= r_last;
        end
    end

    assign o_strobe       = r_res_strobe;
    assign o_hit          = r_res_hit;
    assign o_frame_index  = r_res_index;
    assign o_fault_count  = r_res_fault;
    assign o_sequence_end = r_res_end;

    // every taken request yields a result strobe through the input and result registers
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && start && !busy) |-> ##2 o_strobe)
        else $error("request did not produce a result");

    // fault total never goes backwards
    a_fault_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_fault_total >= $past(r_fault_total)))
        else $error("fault total decreased");

    // a fault result always carries a non-zero fault count
    a_fault_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_hit) |-> (o_fault_count != '0))
        else $error("fault reported with zero fault count");

    // a hit never changes the fault total
    a_hit_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_valid && hit) |=> (r_fault_total == $past(r_fault_total)))
        else $error("fault total moved on a hit");

endmodule
`default_nettype wire
